### sv/triangle_unit_normal_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the triangle unit normal block
// Shared properties clocked on clk; the first two are disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_UNIT_NORMAL_ASSERT_SVH
`define TRIANGLE_UNIT_NORMAL_ASSERT_SVH

// same-cycle implication
`define TUN_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define TUN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// check that also covers the cycle after reset
`define TUN_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

### sv/tun_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_pkg
// Shared constants and the stage control type of the unit normal pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int COORD_WIDTH   = 16;
  localparam int OUT_FRAC_BITS = 14;
  localparam int NORM_WIDTH    = 16;

  typedef struct packed {
    logic       valid;
    logic       degen;
    logic [2:0] neg;
  } tun_ctl_t;

endpackage

### sv/tun_cross.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_cross
// Edge vectors, partial products and exact cross product in three stages.
// ----------------------------------------------------------------------------
module tun_cross #(
  parameter int CW = tun_pkg::COORD_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       valid_i,
  input  logic [8:0][CW-1:0]         pts_i,
  output logic                       valid_o,
  output logic [2:0][2*(CW+1):0]     c_o
);

  localparam int EW  = CW + 1;
  localparam int PW  = 2 * EW;
  localparam int CXW = PW + 1;

  logic [2:0]              v_r;
  logic signed [EW-1:0]    u_r [3];
  logic signed [EW-1:0]    w_r [3];
  logic signed [EW-1:0]    u_nxt [3];
  logic signed [EW-1:0]    w_nxt [3];
  logic signed [PW-1:0]    pr_r [6];
  logic signed [PW-1:0]    pr_nxt [6];
  logic [2:0][CXW-1:0]     c_r;
  logic [2:0][CXW-1:0]     c_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      u_nxt[k] = $signed({pts_i[3+k][CW-1], pts_i[3+k]}) - $signed({pts_i[k][CW-1], pts_i[k]});
      w_nxt[k] = $signed({pts_i[6+k][CW-1], pts_i[6+k]}) - $signed({pts_i[k][CW-1], pts_i[k]});
    end
    pr_nxt[0] = u_r[1] * w_r[2];
    pr_nxt[1] = u_r[2] * w_r[1];
    pr_nxt[2] = u_r[2] * w_r[0];
    pr_nxt[3] = u_r[0] * w_r[2];
    pr_nxt[4] = u_r[0] * w_r[1];
    pr_nxt[5] = u_r[1] * w_r[0];
    for (int k = 0; k < 3; k++) begin
      c_nxt[k] = CXW'($signed({pr_r[2*k][PW-1], pr_r[2*k]})
                 - $signed({pr_r[2*k+1][PW-1], pr_r[2*k+1]}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[1:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u_r  <= u_nxt;
      w_r  <= w_nxt;
      pr_r <= pr_nxt;
      c_r  <= c_nxt;
    end
  end

  assign valid_o = v_r[2];
  assign c_o     = c_r;

endmodule

### sv/tun_square.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_square
// Magnitudes, split squares, squared length and the initial root residuals.
// ----------------------------------------------------------------------------
module tun_square #(
  parameter int CW = tun_pkg::COORD_WIDTH,
  parameter int F  = tun_pkg::OUT_FRAC_BITS,
  parameter int SW = 4 * (CW + 1) + 2,
  parameter int RW = SW + 2 * F + 3
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    valid_i,
  input  logic [2:0][2*(CW+1):0]  c_i,
  output tun_pkg::tun_ctl_t       ctl_o,
  output logic [SW-1:0]           s_o,
  output logic [2:0][RW-1:0]      r_o
);

  localparam int MW  = 2 * (CW + 1);
  localparam int CXW = MW + 1;
  localparam int HW  = (MW + 1) / 2;
  localparam int SQW = 2 * MW;
  localparam int XW  = 4 * HW + 1;

  tun_pkg::tun_ctl_t     ca_r, cb_r, cc_r;
  tun_pkg::tun_ctl_t     ca_nxt, cc_nxt;
  logic [2:0][MW-1:0]    mag;
  logic [2:0][2*HW-1:0]  hh_r, hl_r, ll_r;
  logic [2:0][2*HW-1:0]  hh_nxt, hl_nxt, ll_nxt;
  logic [2:0][SQW-1:0]   sq_r, sq_nxt;
  logic [SW-1:0]         s_r, s_nxt;
  logic [2:0][RW-1:0]    r_r, r_nxt;
  logic [HW-1:0]         hi [3];
  logic [HW-1:0]         lo [3];

  always_comb begin
    ca_nxt       = '0;
    ca_nxt.valid = valid_i;
    for (int k = 0; k < 3; k++) begin
      ca_nxt.neg[k] = c_i[k][CXW-1];
      mag[k]        = c_i[k][CXW-1] ? MW'(-c_i[k]) : MW'(c_i[k]);
      lo[k]         = HW'(mag[k]);
      hi[k]         = HW'(mag[k] >> HW);
      hh_nxt[k]     = hi[k] * hi[k];
      hl_nxt[k]     = hi[k] * lo[k];
      ll_nxt[k]     = lo[k] * lo[k];
      sq_nxt[k]     = SQW'((XW'(hh_r[k]) << (2 * HW)) + (XW'(hl_r[k]) << (HW + 1))
                           + XW'(ll_r[k]));
    end
    s_nxt = SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
    for (int k = 0; k < 3; k++) begin
      r_nxt[k] = RW'(sq_r[k]) << (2 * F);
    end
    cc_nxt       = cb_r;
    cc_nxt.degen = (s_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_r <= '0;
      cb_r <= '0;
      cc_r <= '0;
    end else if (adv) begin
      ca_r <= ca_nxt;
      cb_r <= ca_r;
      cc_r <= cc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hh_r <= hh_nxt;
      hl_r <= hl_nxt;
      ll_r <= ll_nxt;
      sq_r <= sq_nxt;
      s_r  <= s_nxt;
      r_r  <= r_nxt;
    end
  end

  assign ctl_o = cc_r;
  assign s_o   = s_r;
  assign r_o   = r_r;

endmodule

### sv/tun_root_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_root_step
// One quotient bit of floor(|c| * 2^F / sqrt(s)) for all three components.
// ----------------------------------------------------------------------------
module tun_root_step #(
  parameter int SW  = 4 * (tun_pkg::COORD_WIDTH + 1) + 2,
  parameter int RW  = SW + 2 * tun_pkg::OUT_FRAC_BITS + 3,
  parameter int QW  = tun_pkg::OUT_FRAC_BITS + 1,
  parameter int BIT = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  tun_pkg::tun_ctl_t   ctl_i,
  input  logic [SW-1:0]       s_i,
  input  logic [2:0][RW-1:0]  r_i,
  input  logic [2:0][RW-1:0]  p_i,
  input  logic [2:0][QW-1:0]  q_i,
  output tun_pkg::tun_ctl_t   ctl_o,
  output logic [SW-1:0]       s_o,
  output logic [2:0][RW-1:0]  r_o,
  output logic [2:0][RW-1:0]  p_o,
  output logic [2:0][QW-1:0]  q_o
);

  tun_pkg::tun_ctl_t    ctl_r;
  logic [SW-1:0]        s_r;
  logic [2:0][RW-1:0]   r_r, r_nxt, p_r, p_nxt, d;
  logic [2:0][QW-1:0]   q_r, q_nxt;
  logic [2:0]           fits;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d[k]     = (p_i[k] << (BIT + 1)) + (RW'(s_i) << (2 * BIT));
      fits[k]  = (d[k] <= r_i[k]);
      r_nxt[k] = fits[k] ? r_i[k] - d[k] : r_i[k];
      p_nxt[k] = fits[k] ? p_i[k] + (RW'(s_i) << BIT) : p_i[k];
      q_nxt[k] = q_i[k] | (QW'(fits[k]) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_r <= s_i;
      r_r <= r_nxt;
      p_r <= p_nxt;
      q_r <= q_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign s_o   = s_r;
  assign r_o   = r_r;
  assign p_o   = p_r;
  assign q_o   = q_r;

endmodule

### sv/triangle_unit_normal.sv
`timescale 1ns / 1ps
// Throughput: one triangle per cycle; the quotient is found one bit per stage,
// OUT_FRAC_BITS + 1 stages, so the pipeline accepts a new item every cycle while
// not stalled. The pipeline halts as a whole while a held result is stalled.
// Reset: synchronous, active low; clears all valid bits, payload is not reset.
// ----------------------------------------------------------------------------
// triangle_unit_normal
// Unit face normal of a triangle: cross product of edges p1-p0 and p2-p0, divided
// exactly by its length, in signed fixed point; flags a zero cross product.
// ----------------------------------------------------------------------------
`include "triangle_unit_normal_assert.svh"

module triangle_unit_normal #(
  parameter int COORD_WIDTH   = tun_pkg::COORD_WIDTH,
  parameter int OUT_FRAC_BITS = tun_pkg::OUT_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [COORD_WIDTH-1:0]        in_p0_x,
  input  logic signed [COORD_WIDTH-1:0]        in_p0_y,
  input  logic signed [COORD_WIDTH-1:0]        in_p0_z,
  input  logic signed [COORD_WIDTH-1:0]        in_p1_x,
  input  logic signed [COORD_WIDTH-1:0]        in_p1_y,
  input  logic signed [COORD_WIDTH-1:0]        in_p1_z,
  input  logic signed [COORD_WIDTH-1:0]        in_p2_x,
  input  logic signed [COORD_WIDTH-1:0]        in_p2_y,
  input  logic signed [COORD_WIDTH-1:0]        in_p2_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [tun_pkg::NORM_WIDTH-1:0] out_normal_x,
  output logic signed [tun_pkg::NORM_WIDTH-1:0] out_normal_y,
  output logic signed [tun_pkg::NORM_WIDTH-1:0] out_normal_z,
  output logic                                 out_degenerate
);

  localparam int F   = OUT_FRAC_BITS;
  localparam int MW  = 2 * (COORD_WIDTH + 1);
  localparam int SW  = 2 * MW + 2;
  localparam int RW  = SW + 2 * F + 3;
  localparam int QW  = F + 1;
  localparam int NW  = tun_pkg::NORM_WIDTH;
  localparam int XW  = (QW + 1 > NW) ? QW + 1 : NW;

  logic                          adv;
  logic [8:0][COORD_WIDTH-1:0]   pts;
  logic                          cx_valid;
  logic [2:0][MW:0]              cx;

  tun_pkg::tun_ctl_t             ctl_s [QW+1];
  logic [SW-1:0]                 s_s   [QW+1];
  logic [2:0][RW-1:0]            r_s   [QW+1];
  logic [2:0][RW-1:0]            p_s   [QW+1];
  logic [2:0][QW-1:0]            q_s   [QW+1];

  logic                          out_valid_r;
  logic                          degen_r, degen_nxt;
  logic [2:0][NW-1:0]            norm_r, norm_nxt;
  logic signed [XW-1:0]          qx [3];

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  assign pts = {in_p2_z, in_p2_y, in_p2_x, in_p1_z, in_p1_y, in_p1_x,
                in_p0_z, in_p0_y, in_p0_x};

  tun_cross #(.CW(COORD_WIDTH)) u_cross (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .valid_i (in_valid),
    .pts_i   (pts),
    .valid_o (cx_valid),
    .c_o     (cx)
  );

  tun_square #(.CW(COORD_WIDTH), .F(F), .SW(SW), .RW(RW)) u_square (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .valid_i (cx_valid),
    .c_i     (cx),
    .ctl_o   (ctl_s[0]),
    .s_o     (s_s[0]),
    .r_o     (r_s[0])
  );

  assign p_s[0] = '0;
  assign q_s[0] = '0;

  for (genvar j = 0; j < QW; j++) begin : g_step
    tun_root_step #(.SW(SW), .RW(RW), .QW(QW), .BIT(F - j)) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .ctl_i (ctl_s[j]),
      .s_i   (s_s[j]),
      .r_i   (r_s[j]),
      .p_i   (p_s[j]),
      .q_i   (q_s[j]),
      .ctl_o (ctl_s[j+1]),
      .s_o   (s_s[j+1]),
      .r_o   (r_s[j+1]),
      .p_o   (p_s[j+1]),
      .q_o   (q_s[j+1])
    );
  end

  always_comb begin
    degen_nxt = ctl_s[QW].degen;
    for (int k = 0; k < 3; k++) begin
      qx[k]       = ctl_s[QW].neg[k] ? -$signed(XW'(q_s[QW][k])) : $signed(XW'(q_s[QW][k]));
      norm_nxt[k] = degen_nxt ? '0 : NW'(qx[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl_s[QW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      norm_r  <= norm_nxt;
      degen_r <= degen_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_normal_x   = norm_r[0];
  assign out_normal_y   = norm_r[1];
  assign out_normal_z   = norm_r[2];
  assign out_degenerate = degen_r;

  `TUN_ASSERT_IMPL(a_degen_zero, out_valid_r && degen_r, norm_r == '0)
  `TUN_ASSERT_IMPL(a_stall_only_full, in_stall, out_valid_r && out_stall)
  `TUN_ASSERT_NEXT(a_hold_result, out_valid_r && out_stall, out_valid_r && $stable(norm_r))
  `TUN_ASSERT_RST(a_reset_empty, !$past(rst_n), !out_valid_r)

endmodule

### sim/triangle_unit_normal_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_unit_normal_tb
// Streams triangles through the unit normal block under random idling on
// both sides and checks every normal and degenerate flag against an exact
// integer square-root-free computation of the truncated unit normal.
// ----------------------------------------------------------------------------
module triangle_unit_normal_tb;

  typedef logic signed [tun_pkg::COORD_WIDTH-1:0] coord_t;
  typedef logic signed [tun_pkg::NORM_WIDTH-1:0] norm_t;

  typedef struct {
    norm_t nx;
    norm_t ny;
    norm_t nz;
    logic  degen;
  } face_normal_t;

  localparam int CYCLE_LIMIT = 300000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t in_p0_x = '0, in_p0_y = '0, in_p0_z = '0;
  coord_t in_p1_x = '0, in_p1_y = '0, in_p1_z = '0;
  coord_t in_p2_x = '0, in_p2_y = '0, in_p2_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  norm_t out_normal_x, out_normal_y, out_normal_z;
  logic out_degenerate;

  face_normal_t normals_due[$];
  int errors = 0;
  int transfers_in = 0;
  int transfers_out = 0;
  int degen_seen = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  int hold_req = 0;

  triangle_unit_normal u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_p0_x(in_p0_x), .in_p0_y(in_p0_y), .in_p0_z(in_p0_z),
    .in_p1_x(in_p1_x), .in_p1_y(in_p1_y), .in_p1_z(in_p1_z),
    .in_p2_x(in_p2_x), .in_p2_y(in_p2_y), .in_p2_z(in_p2_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_normal_z(out_normal_z), .out_degenerate(out_degenerate)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [127:0] mag128(longint v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  function automatic face_normal_t face_normal(coord_t pt[9]);
    longint ux, uy, uz, vx, vy, vz;
    longint c[3];
    logic [127:0] len2, target, t, cm;
    logic [127:0] q;
    norm_t comp[3];
    face_normal_t r;
    ux = longint'(pt[3]) - longint'(pt[0]);
    uy = longint'(pt[4]) - longint'(pt[1]);
    uz = longint'(pt[5]) - longint'(pt[2]);
    vx = longint'(pt[6]) - longint'(pt[0]);
    vy = longint'(pt[7]) - longint'(pt[1]);
    vz = longint'(pt[8]) - longint'(pt[2]);
    c[0] = uy * vz - uz * vy;
    c[1] = uz * vx - ux * vz;
    c[2] = ux * vy - uy * vx;
    if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
      r.nx = '0; r.ny = '0; r.nz = '0; r.degen = 1'b1;
      return r;
    end
    len2 = mag128(c[0]) * mag128(c[0]) + mag128(c[1]) * mag128(c[1])
         + mag128(c[2]) * mag128(c[2]);
    for (int i = 0; i < 3; i++) begin
      cm = mag128(c[i]);
      target = (cm * cm) << (2 * tun_pkg::OUT_FRAC_BITS);
      q = '0;
      for (int b = tun_pkg::OUT_FRAC_BITS; b >= 0; b--) begin
        t = q | (128'd1 << b);
        if (t * t * len2 <= target) q = t;
      end
      if (c[i] < 0) q = -q;
      comp[i] = q[tun_pkg::NORM_WIDTH-1:0];
    end
    r.nx = comp[0]; r.ny = comp[1]; r.nz = comp[2]; r.degen = 1'b0;
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
  endtask

  always @(posedge clk) begin
    face_normal_t e;
    if (rst_n && out_valid && !out_stall) begin
      transfers_out++;
      if (normals_due.size() == 0) begin
        report("unexpected transfer, degenerate", out_degenerate, -1);
      end else begin
        e = normals_due.pop_front();
        if (out_normal_x !== e.nx) report("normal_x", out_normal_x, e.nx);
        if (out_normal_y !== e.ny) report("normal_y", out_normal_y, e.ny);
        if (out_normal_z !== e.nz) report("normal_z", out_normal_z, e.nz);
        if (out_degenerate !== e.degen) report("degenerate", out_degenerate, e.degen);
        if (e.degen) degen_seen++;
      end
    end
  end

  // receiver: random stall bursts, plus a long hold on request
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        out_stall <= 1'b1;
        hold_req--;
      end else if (burst > 0 && !quiet) begin
        out_stall <= 1'b1;
        burst--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        burst = $urandom_range(1, 18) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_triangle(coord_t pt[9], bit may_idle);
    in_valid <= 1'b1;
    in_p0_x <= pt[0]; in_p0_y <= pt[1]; in_p0_z <= pt[2];
    in_p1_x <= pt[3]; in_p1_y <= pt[4]; in_p1_z <= pt[5];
    in_p2_x <= pt[6]; in_p2_y <= pt[7]; in_p2_z <= pt[8];
    do @(posedge clk); while (in_stall);
    normals_due.push_back(face_normal(pt));
    transfers_in++;
    if (may_idle && !quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  function automatic coord_t rand_coord(int span);
    if (span >= 32768) return coord_t'($urandom);
    return coord_t'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic send_random(int span);
    coord_t pt[9];
    foreach (pt[k]) pt[k] = rand_coord(span);
    send_triangle(pt, 1'b1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (normals_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    coord_t z[9], pt[9];
    foreach (z[k]) z[k] = '0;
    send_triangle(z, 1'b1);
    pt = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
    send_triangle(pt, 1'b1);
    pt = '{0, 0, 0, 256, 0, 0, 0, 256, 0};
    send_triangle(pt, 1'b1);
    pt = '{0, 0, 0, 0, 256, 0, 256, 0, 0};
    send_triangle(pt, 1'b1);
    pt = '{0, 0, 0, 0, 0, 1, 1, 0, 0};
    send_triangle(pt, 1'b1);
    pt = '{0, 0, 0, 0, 1, 0, 0, 0, 1};
    send_triangle(pt, 1'b1);
    pt = '{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768};
    send_triangle(pt, 1'b1);
    pt = '{32767, 32767, 32767, -32768, 32767, 32767, 32767, 32767, -32768};
    send_triangle(pt, 1'b1);
    pt = '{-32768, 32767, -32768, 32767, -32768, 32767, 32767, 32767, -32768};
    send_triangle(pt, 1'b1);
    pt = '{1, 2, 3, 2, 4, 6, 3, 6, 9};
    send_triangle(pt, 1'b1);
    pt = '{100, 100, 100, 100, 100, 100, 5, 7, 9};
    send_triangle(pt, 1'b1);
    pt = '{0, 0, 0, 32767, 1, 0, 1, 32767, 0};
    send_triangle(pt, 1'b1);
    pt = '{0, 0, 0, 1, 1, 1, -1, 2, -3};
    send_triangle(pt, 1'b1);
    pt = '{-1, -1, -1, 0, 0, 0, 0, 0, 0};
    send_triangle(pt, 1'b1);
    drain();
  endtask

  task automatic test_random_full();
    repeat (500) send_random(32768);
  endtask

  task automatic test_random_small();
    repeat (300) send_random($urandom_range(1, 3));
  endtask

  task automatic test_backpressure();
    hold_req = 400;
    repeat (60) send_random(32768);
    drain();
  endtask

  task automatic test_full_rate();
    quiet = 1'b1;
    repeat (240) send_random(($urandom_range(0, 3) == 0) ? 2 : 32768);
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_full();
    test_random_small();
    test_backpressure();
    test_full_rate();
    while (normals_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("sent %0d triangles, checked %0d normals (%0d degenerate)",
             transfers_in, transfers_out, degen_seen);
    $display("covered extremes, degenerate and axis-aligned cases, stalls and full rate");
    if (errors == 0 && normals_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d errors, %0d results missing", errors, normals_due.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
